// ===== design/racu_pkg.sv =====
// Shared types and constants for the recurrent affine byte cipher unit.
package racu_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Register indexes, taken from paddr[4:2]
	localparam logic [2:0] REG_DECRYPT_MODE      = 3'd0;
	localparam logic [2:0] REG_FIRST_MULTIPLIER  = 3'd1;
	localparam logic [2:0] REG_FIRST_OFFSET      = 3'd2;
	localparam logic [2:0] REG_SECOND_MULTIPLIER = 3'd3;
	localparam logic [2:0] REG_SECOND_OFFSET     = 3'd4;

	// Byte position within a message
	localparam logic [1:0] POS_NONE   = 2'd0;
	localparam logic [1:0] POS_FIRST  = 2'd1;
	localparam logic [1:0] POS_SECOND = 2'd2;
	localparam logic [1:0] POS_LATER  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_TEST,
		ST_REFINE,
		ST_DATA
	} state_t;

	typedef struct packed {
		logic       decrypt_mode;
		logic [7:0] first_multiplier;
		logic [7:0] first_offset;
		logic [7:0] second_multiplier;
		logic [7:0] second_offset;
	} cfg_t;

endpackage

// ===== design/racu_mul.sv =====
// Shared 8-bit multiply-add unit, result modulo 256.
module racu_mul import racu_pkg::*; (
	input  logic [7:0] opa,
	input  logic [7:0] opb,
	input  logic [7:0] opc,
	output logic [7:0] prod
);

	logic [15:0] full;

	always_comb begin
		full = opa * opb;
		prod = full[7:0] + opc;
	end

endmodule

// ===== design/racu_cfg.sv =====
// APB register bank holding the key pairs and the mode bit.
module racu_cfg import racu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       regs_q;
	logic       wr_en;
	logic [2:0] index;

	assign pready = 1'b1;
	assign index  = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.decrypt_mode      <= 1'b0;
			regs_q.first_multiplier  <= 8'd1;
			regs_q.first_offset      <= 8'd0;
			regs_q.second_multiplier <= 8'd1;
			regs_q.second_offset     <= 8'd0;
		end else if (wr_en) begin
			case (index)
				REG_DECRYPT_MODE:      regs_q.decrypt_mode      <= pwdata[0];
				REG_FIRST_MULTIPLIER:  regs_q.first_multiplier  <= pwdata[7:0];
				REG_FIRST_OFFSET:      regs_q.first_offset      <= pwdata[7:0];
				REG_SECOND_MULTIPLIER: regs_q.second_multiplier <= pwdata[7:0];
				REG_SECOND_OFFSET:     regs_q.second_offset     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			REG_DECRYPT_MODE:      prdata = {{(DATA_W-1){1'b0}}, regs_q.decrypt_mode};
			REG_FIRST_MULTIPLIER:  prdata = {{(DATA_W-8){1'b0}}, regs_q.first_multiplier};
			REG_FIRST_OFFSET:      prdata = {{(DATA_W-8){1'b0}}, regs_q.first_offset};
			REG_SECOND_MULTIPLIER: prdata = {{(DATA_W-8){1'b0}}, regs_q.second_multiplier};
			REG_SECOND_OFFSET:     prdata = {{(DATA_W-8){1'b0}}, regs_q.second_offset};
			default:               prdata = '0;
		endcase
	end

endmodule

// ===== design/recurrent_affine_byte_cipher_unit.sv =====
// Recurrent affine byte cipher: key sequencer around one shared 8-bit multiplier.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, data_byte, message_start | to block
//  out     | out_valid, out_ready, result_byte          | from block
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB
//
// Encrypting the first or second byte of a message runs idle then data; later bytes
// take a key step between them; decrypting adds two Newton steps of the inverse,
// each a test and a refine, before idle takes the next word. All products go through the one multiplier.
// Reset loads the register reset values at once; no clearing pass.
// The output register lets a new word enter while the last result waits;
// the final multiply step holds until that result is taken.
module recurrent_affine_byte_cipher_unit import racu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              message_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        result_byte
);

	cfg_t       cfg;
	state_t     state_q, state_d;
	logic [1:0] pos_q;
	logic [7:0] older_mul_q, older_off_q, newer_mul_q, newer_off_q;
	logic [7:0] a_q, b_q, inv_q, t_q, x_q, result_q;
	logic       iter_q, out_valid_q;
	logic [7:0] opa, opb, opc, prod;
	logic [7:0] first_mul, second_mul;
	logic       in_acc, load_out, is_first;

	racu_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	racu_mul u_mul (
		.opa (opa),
		.opb (opb),
		.opc (opc),
		.prod(prod)
	);

	assign first_mul   = cfg.first_multiplier | 8'd1;
	assign second_mul  = cfg.second_multiplier | 8'd1;
	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign load_out    = (state_q == ST_DATA) && (!out_valid_q || out_ready);
	assign is_first    = message_start || (pos_q inside {POS_NONE, POS_FIRST});
	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operand select
	always_comb begin
		state_d = state_q;
		opa     = 8'd0;
		opb     = 8'd0;
		opc     = 8'd0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (is_first || pos_q == POS_SECOND) begin
						state_d = cfg.decrypt_mode ? ST_TEST : ST_DATA;
					end else begin
						state_d = ST_KEY;
					end
				end
			end
			ST_KEY: begin
				opa     = older_mul_q;
				opb     = newer_mul_q;
				state_d = cfg.decrypt_mode ? ST_TEST : ST_DATA;
			end
			ST_TEST: begin
				opa     = a_q;
				opb     = inv_q;
				state_d = ST_REFINE;
			end
			ST_REFINE: begin
				opa     = inv_q;
				opb     = 8'd2 - t_q;
				state_d = iter_q ? ST_DATA : ST_TEST;
			end
			ST_DATA: begin
				if (cfg.decrypt_mode) begin
					opa = inv_q;
					opb = x_q - b_q;
				end else begin
					opa = a_q;
					opb = x_q;
					opc = b_q;
				end
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Key sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_FIRST;
			older_mul_q <= 8'd0;
			older_off_q <= 8'd0;
			newer_mul_q <= 8'd0;
			newer_off_q <= 8'd0;
		end else if (in_acc) begin
			if (is_first) begin
				newer_mul_q <= first_mul;
				newer_off_q <= cfg.first_offset;
				pos_q       <= POS_SECOND;
			end else if (pos_q == POS_SECOND) begin
				older_mul_q <= first_mul;
				older_off_q <= cfg.first_offset;
				newer_mul_q <= second_mul;
				newer_off_q <= cfg.second_offset;
				pos_q       <= POS_LATER;
			end
		end else if (state_q == ST_KEY) begin
			older_mul_q <= newer_mul_q;
			older_off_q <= newer_off_q;
			newer_mul_q <= prod;
			newer_off_q <= older_off_q + newer_off_q;
		end
	end

	// Working registers for the current word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				iter_q <= 1'b0;
				if (in_acc) begin
					x_q <= data_byte;
					if (is_first) begin
						a_q   <= first_mul;
						inv_q <= first_mul;
						b_q   <= cfg.first_offset;
					end else if (pos_q == POS_SECOND) begin
						a_q   <= second_mul;
						inv_q <= second_mul;
						b_q   <= cfg.second_offset;
					end
				end
			end
			ST_KEY: begin
				a_q   <= prod;
				inv_q <= prod;
				b_q   <= older_off_q + newer_off_q;
			end
			ST_TEST:   t_q <= prod;
			ST_REFINE: begin
				inv_q  <= prod;
				iter_q <= ~iter_q;
			end
			ST_DATA: begin
				if (load_out) begin
					result_q <= prod;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != POS_NONE)
		else $error("byte position reached zero");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready right after accepting a word");

	a_multiplier_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST || state_q == ST_DATA) |-> a_q[0])
		else $error("even multiplier key in use");

	a_inverse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA && cfg.decrypt_mode) |-> (8'(a_q * inv_q) == 8'd1))
		else $error("multiplier inverse wrong at data step");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the recurrent affine byte cipher unit: directed table, then random traffic.
module testbench import racu_pkg::*;;

	localparam int unsigned STALL_LIMIT     = 2000;
	localparam int unsigned DRAIN_PAD       = 12;
	localparam int unsigned PHASES          = 10;
	localparam int unsigned WORDS_PER_PHASE = 200;

	// register slots past the end of the map; writes there must be dropped
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  index;
		logic [31:0] value;
		logic [7:0]  data;
		logic        start;
		logic        has_result;
		logic [7:0]  result;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        data_byte;
	logic              message_start;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        result_byte;

	// key registers as the block should hold them, and the running key sequence
	cfg_t       keys;
	logic [1:0] key_pos;
	logic [7:0] mult_old;
	logic [7:0] offset_old;
	logic [7:0] mult_new;
	logic [7:0] offset_new;

	logic [7:0] expected_bytes[$];
	plan_row_t  plan[$];
	bit         steady;
	int         mismatches;
	int         results_seen;
	int         words_sent;
	int         words_decrypted;
	int         settings_used;

	recurrent_affine_byte_cipher_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.message_start(message_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_byte  (result_byte)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic logic [31:0] draw_key();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'hFF;
			2: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Advance the key sequence by one byte and return the cipher output.
	function automatic logic [7:0] predict_cipher(input logic [7:0] x, input logic start);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] inv;
		logic [7:0] diff;
		if (start || key_pos == POS_NONE)
			key_pos = POS_FIRST;
		case (key_pos)
			POS_FIRST: begin
				a = keys.first_multiplier | 8'h01;
				b = keys.first_offset;
				key_pos = POS_SECOND;
			end
			POS_SECOND: begin
				a = keys.second_multiplier | 8'h01;
				b = keys.second_offset;
				// first key is read again here, so a late write to it counts
				mult_new = keys.first_multiplier | 8'h01;
				offset_new = keys.first_offset;
				key_pos = POS_LATER;
			end
			default: begin
				a = 8'(mult_old * mult_new);
				b = 8'(offset_old + offset_new);
			end
		endcase
		mult_old = mult_new;
		offset_old = offset_new;
		mult_new = a;
		offset_new = b;
		if (keys.decrypt_mode) begin
			words_decrypted++;
			inv = 8'h01;
			for (int i = 1; i < 256; i += 2)
				if (8'(a * i) == 8'h01)
					inv = 8'(i);
			diff = x - b;
			return 8'(inv * diff);
		end
		return 8'(a * x + b);
	endfunction

	function automatic void plan_word(input logic [7:0] d, input logic s,
			input logic has_res, input logic [7:0] res);
		plan_row_t row;
		row = '{ROW_WORD, 3'd0, 32'd0, d, s, has_res, res};
		plan = {plan, row};
	endfunction

	function automatic void plan_write(input logic [2:0] idx, input logic [31:0] val);
		plan_row_t row;
		row = '{ROW_WRITE, idx, val, 8'd0, 1'b0, 1'b0, 8'd0};
		plan = {plan, row};
	endfunction

	task automatic send_word(input logic [7:0] d, input logic s,
			input logic has_res, input logic [7:0] res);
		int gap;
		logic [7:0] predicted;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		message_start <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_cipher(d, s);
		expected_bytes = {expected_bytes, (has_res ? res : predicted)};
		words_sent++;
	endtask

	// Drop valid and let the block run dry before touching the keys.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_DECRYPT_MODE:      keys.decrypt_mode = val[0];
			REG_FIRST_MULTIPLIER:  keys.first_multiplier = val[7:0];
			REG_FIRST_OFFSET:      keys.first_offset = val[7:0];
			REG_SECOND_MULTIPLIER: keys.second_multiplier = val[7:0];
			REG_SECOND_OFFSET:     keys.second_offset = val[7:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random stalls, compare against the oldest expected byte
	initial begin
		int stall;
		logic [7:0] want;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %02h with nothing pending", result_byte);
			end else begin
				want = expected_bytes.pop_front();
				results_seen++;
				if (result_byte !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %02h, got %02h",
							results_seen, want, result_byte);
				end
			end
		end
	end

	// watchdog: end the run when no channel has moved for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(psel && penable && pwrite && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
		$display("recurrent_affine_byte_cipher_unit: mismatch");
		$finish;
	end

	initial begin
		logic [31:0] val;
		int phase_words;
		int len;
		bit noise;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		message_start <= 1'b0;
		out_ready <= 1'b0;
		arst_n <= 1'b0;
		steady = 1'b0;
		mismatches = 0;
		results_seen = 0;
		words_sent = 0;
		words_decrypted = 0;
		settings_used = 1;
		keys = '{decrypt_mode: 1'b0, first_multiplier: 8'h01, first_offset: 8'h00,
			second_multiplier: 8'h01, second_offset: 8'h00};
		key_pos = POS_FIRST;
		mult_old = 8'h00;
		offset_old = 8'h00;
		mult_new = 8'h00;
		offset_new = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset keys give the identity; first byte needs no start mark
		plan_word(8'h00, 1'b0, 1'b1, 8'h00);
		plan_word(8'hFF, 1'b0, 1'b1, 8'hFF);
		plan_word(8'h80, 1'b0, 1'b1, 8'h80);
		plan_word(8'h01, 1'b1, 1'b1, 8'h01);
		// even multipliers get bit 0 forced
		plan_write(REG_FIRST_MULTIPLIER, 32'h02);
		plan_write(REG_FIRST_OFFSET, 32'hFF);
		plan_write(REG_SECOND_MULTIPLIER, 32'hFE);
		plan_write(REG_SECOND_OFFSET, 32'h01);
		plan_word(8'h00, 1'b1, 1'b1, 8'hFF);
		plan_word(8'hFF, 1'b0, 1'b1, 8'h02);
		plan_word(8'h55, 1'b0, 1'b0, 8'h00);
		plan_word(8'hAA, 1'b0, 1'b0, 8'h00);
		plan_write(REG_SPARE_LO, 32'hFFFF_FFFF);
		plan_write(REG_SPARE_HI, 32'h0000_0001);
		plan_word(8'h12, 1'b0, 1'b0, 8'h00);
		plan_write(REG_DECRYPT_MODE, 32'h1);
		plan_word(8'hFF, 1'b1, 1'b1, 8'h00);
		plan_word(8'h02, 1'b0, 1'b1, 8'hFF);
		plan_word(8'h00, 1'b0, 1'b0, 8'h00);
		plan_word(8'h80, 1'b0, 1'b0, 8'h00);
		// second key changes mid-message: only the next message sees it
		plan_write(REG_SECOND_OFFSET, 32'h80);
		plan_word(8'h33, 1'b0, 1'b0, 8'h00);
		plan_word(8'h44, 1'b1, 1'b0, 8'h00);
		plan_word(8'h45, 1'b0, 1'b0, 8'h00);
		plan_write(REG_FIRST_MULTIPLIER, 32'hFF);
		plan_write(REG_FIRST_OFFSET, 32'h00);
		plan_write(REG_SECOND_MULTIPLIER, 32'h01);
		plan_write(REG_SECOND_OFFSET, 32'hFF);
		plan_word(8'hFF, 1'b1, 1'b1, 8'h01);
		plan_word(8'h00, 1'b0, 1'b1, 8'h01);
		plan_word(8'h7F, 1'b0, 1'b0, 8'h00);
		plan_write(REG_DECRYPT_MODE, 32'hFFFF_FFFE);
		plan_word(8'h80, 1'b1, 1'b0, 8'h00);
		// first key is read again at the second byte
		plan_write(REG_FIRST_MULTIPLIER, 32'h10);
		plan_word(8'h01, 1'b0, 1'b1, 8'h00);
		plan_word(8'hFE, 1'b0, 1'b0, 8'h00);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				settle();
				apb_write(plan[r].index, plan[r].value);
				settings_used++;
			end else begin
				send_word(plan[r].data, plan[r].start, plan[r].has_result, plan[r].result);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			steady = (phase % 4 == 2);
			val = $urandom();
			val[0] = (phase % 2 == 1);
			apb_write(REG_DECRYPT_MODE, val);
			if (phase == 0 || $urandom_range(0, 3) != 0)
				apb_write(REG_FIRST_MULTIPLIER, draw_key());
			if (phase == 0 || $urandom_range(0, 3) != 0)
				apb_write(REG_FIRST_OFFSET, draw_key());
			if (phase == 0 || $urandom_range(0, 3) != 0)
				apb_write(REG_SECOND_MULTIPLIER, draw_key());
			if (phase == 0 || $urandom_range(0, 3) != 0)
				apb_write(REG_SECOND_OFFSET, draw_key());
			if ($urandom_range(0, 3) == 0)
				apb_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
			settings_used++;
			phase_words = 0;
			while (phase_words < WORDS_PER_PHASE) begin
				noise = ($urandom_range(0, 9) >= 8);
				if (noise)
					len = $urandom_range(1, 6);
				else if ($urandom_range(0, 7) == 0)
					len = $urandom_range(25, 100);
				else
					len = $urandom_range(1, 24);
				for (int k = 0; k < len; k++) begin
					// a message mostly opens with a start mark; sometimes run on
					if (noise)
						send_word(8'($urandom()), 1'($urandom_range(0, 1)), 1'b0, 8'h00);
					else
						send_word(8'($urandom()), k == 0 && $urandom_range(0, 5) != 0,
							1'b0, 8'h00);
				end
				phase_words += len;
			end
		end

		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
		$display("%0d bytes sent over %0d key settings, %0d of them decrypted",
			words_sent, settings_used, words_decrypted);
		$display("%0d result bytes compared, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("recurrent_affine_byte_cipher_unit: match");
		else
			$display("recurrent_affine_byte_cipher_unit: mismatch");
		$finish;
	end

endmodule
